[rtl/csp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types and constants for the cubic spline point evaluator.
// ----------------------------------------------------------------------------
package csp_pkg;

   localparam int DEF_MAX_POINTS = 16;
   localparam int DEF_COORD_BITS = 32;
   localparam int OUT_BITS       = 32;
   localparam int FRAC_BITS      = 16;
   localparam int PARAM_BITS     = 17;
   localparam int CMD_BITS       = 2;
   localparam int IDX_BITS       = 4;
   localparam int CNT_BITS       = 5;
   localparam int KIND_BITS      = 2;
   localparam int CSR_ADDR_BITS  = 2;
   localparam int CSR_DATA_BITS  = 5;
   // working width of coefficients and Horner accumulator
   localparam int ACC_BITS       = 40;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_WR_POS  = 2'd0,
      CMD_WR_TIN  = 2'd1,
      CMD_WR_TOUT = 2'd2,
      CMD_EVAL    = 2'd3
   } cmd_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_LINEAR = 2'd0,
      KIND_CATROM = 2'd1,
      KIND_BEZIER = 2'd2,
      KIND_CATALT = 2'd3
   } kind_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_POINTS = 2'd0,
      CSR_LOOP   = 2'd1,
      CSR_KIND   = 2'd2,
      CSR_SPARE  = 2'd3
   } csr_type;

   // result shaping carried down the pipe
   typedef struct packed {
      logic       zero;   // no points
      logic       single; // one point
      logic       halve;  // Catmull-Rom final halving
   } mode_type;

endpackage

`default_nettype wire

[rtl/csp_horner_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csp_horner_step
// One registered Horner step: acc_out = R(acc * f) + c, R = round half up.
// ----------------------------------------------------------------------------
module csp_horner_step import csp_pkg::*; (
   input  wire logic                        clock,
   input  wire logic                        enable,
   input  wire logic signed [ACC_BITS-1:0]  acc,
   input  wire logic        [FRAC_BITS:0]   frac,
   input  wire logic signed [ACC_BITS-1:0]  coef,
   output logic signed [ACC_BITS-1:0]       acc_out
);

   localparam int PROD_BITS = ACC_BITS + FRAC_BITS + 2;

   logic signed [PROD_BITS-1:0] prod;
   logic signed [PROD_BITS-1:0] rnd;
   logic signed [ACC_BITS-1:0]  acc_ff;
   logic signed [ACC_BITS-1:0]  acc_in;

   always_comb begin
      prod   = PROD_BITS'(acc) * $signed({1'b0, frac});
      rnd    = (prod + PROD_BITS'(32'sd32768)) >>> FRAC_BITS;
      acc_in = ACC_BITS'(rnd) + coef;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         acc_ff <= acc_in;
      end
   end

   assign acc_out = acc_ff;

endmodule

`default_nettype wire

[rtl/csp_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csp_front
// Segment split and neighbour index selection for an evaluate transfer.
// ----------------------------------------------------------------------------
module csp_front import csp_pkg::*; #(
   parameter int MAX_POINTS = DEF_MAX_POINTS,
   parameter int IW         = $clog2(MAX_POINTS)
) (
   input  wire logic                  clock,
   input  wire logic                  enable,
   input  wire logic [CNT_BITS-1:0]   points_in_use,
   input  wire logic                  loop_mode,
   input  wire logic [PARAM_BITS-1:0] curve_param,
   output logic [IW-1:0]              idx_m1,
   output logic [IW-1:0]              idx_0,
   output logic [IW-1:0]              idx_p1,
   output logic [IW-1:0]              idx_p2,
   output logic [FRAC_BITS:0]         frac,
   output logic                       n_zero,
   output logic                       n_one
);

   localparam int NW = $clog2(MAX_POINTS + 1) + 1;
   localparam int SW = PARAM_BITS + NW;

   logic [NW-1:0]         n_eff;
   logic [NW-1:0]         segs;
   logic [PARAM_BITS-1:0] t_sat;
   logic [SW-1:0]         s;
   logic [NW-1:0]         seg;
   logic [FRAC_BITS:0]    f_in;
   logic [NW-1:0]         n_ff, seg_ff;
   logic                  loop_ff;
   logic [FRAC_BITS:0]    f_ff;

   function automatic logic [IW-1:0] nb(input logic signed [NW+1:0] i,
                                        input logic [NW-1:0] n,
                                        input logic lp);
      logic signed [NW+1:0] r;
      logic signed [NW+1:0] ns;
      ns = $signed({2'b00, n});
      r  = i;
      if (lp) begin
         if (r < 0) r = r + ns;
         if (r >= ns) r = r - ns;
         if (r >= ns) r = r - ns;
      end else begin
         if (r < 0) r = '0;
         if (r > ns - 1) r = ns - 1;
      end
      return IW'(r);
   endfunction

   always_comb begin
      if (32'(points_in_use) > MAX_POINTS) begin
         n_eff = NW'(MAX_POINTS);
      end else begin
         n_eff = NW'(points_in_use);
      end
      t_sat = (curve_param > PARAM_BITS'(1 << FRAC_BITS)) ?
              PARAM_BITS'(1 << FRAC_BITS) : curve_param;
      segs  = loop_mode ? n_eff : n_eff - NW'(1);
      s     = SW'(t_sat) * SW'(segs);
      seg   = NW'(s >> FRAC_BITS);
      f_in  = {1'b0, s[FRAC_BITS-1:0]};
      if (seg >= segs) begin
         seg  = segs - NW'(1);
         f_in = (FRAC_BITS+1)'(1 << FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         n_ff    <= n_eff;
         seg_ff  <= seg;
         loop_ff <= loop_mode;
         f_ff    <= f_in;
         idx_m1  <= nb($signed({2'b00, seg_ff}) - (NW+2)'(1), n_ff, loop_ff);
         idx_0   <= nb($signed({2'b00, seg_ff}), n_ff, loop_ff);
         idx_p1  <= nb($signed({2'b00, seg_ff}) + (NW+2)'(1), n_ff, loop_ff);
         idx_p2  <= nb($signed({2'b00, seg_ff}) + (NW+2)'(2), n_ff, loop_ff);
         frac    <= f_ff;
         n_zero  <= (n_ff == '0);
         n_one   <= (n_ff == NW'(1));
      end
   end

endmodule

`default_nettype wire

[rtl/cubic_spline_point_evaluator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_spline_point_evaluator
// Control point table and pipelined linear / Catmull-Rom / Bezier evaluator.
//
// req_ carries write and evaluate transfers; writes update one vector of one
// point table entry and produce nothing, evaluates produce one rsp_ transfer
// with the Q16.16 point, saturated. csr_ sets point count, loop and kind;
// the user must write it only while idle, which the block does not enforce.
// The pipeline is 8 stages: two for segment split and indexing, one table
// read, one coefficient stage, three Horner multiply steps and one output
// stage; it sustains one transfer per cycle while the receiver does not stall.
// Table writes travel two stages before landing, in step with the read stage.
// Every stage advances together when the output register is empty or taken,
// so a stalled receiver holds the pipe without losing or repeating data.
// Reset clears the valid bits and config; table contents stay undefined
// until written.
// ----------------------------------------------------------------------------
module cubic_spline_point_evaluator import csp_pkg::*; #(
   parameter int MAX_POINTS = DEF_MAX_POINTS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // command[1:0], point_index[5:2], vec_x[37:6], vec_y[69:38], vec_z[101:70],
   // curve_param[118:102], zero fill
   input  wire logic [119:0]             req_tdata,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // pos_x[31:0], pos_y[63:32], pos_z[95:64]
   output logic [95:0]                   rsp_tdata,
   input  wire logic                     csr_we,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int IW    = $clog2(MAX_POINTS);
   localparam int EB    = (COORD_BITS < 32) ? COORD_BITS : 32;
   localparam int DEPTH = 8;

   logic [CNT_BITS-1:0]  points_ff;
   logic                 loop_ff;
   kind_type             kind_ff;

   logic                 adv;
   logic [DEPTH-1:0]     vld_ff;

   cmd_type              cmd;
   cmd_type              wcmd;
   logic [IDX_BITS-1:0]  widx;
   logic signed [ACC_BITS-1:0] wv [3];
   logic                 wr1_ff, wr2_ff;
   logic [101:0]         wd1_ff, wd2_ff;

   logic signed [ACC_BITS-1:0] pos_mem  [MAX_POINTS][3];
   logic signed [ACC_BITS-1:0] tin_mem  [MAX_POINTS][3];
   logic signed [ACC_BITS-1:0] tout_mem [MAX_POINTS][3];

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[DEPTH-1];
   assign cmd        = cmd_type'(req_tdata[1:0]);
   assign wcmd       = cmd_type'(wd2_ff[1:0]);
   assign widx       = wd2_ff[5:2];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         wv[j] = ACC_BITS'($signed(wd2_ff[6+32*j +: EB]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= '0;
         loop_ff   <= 1'b0;
         kind_ff   <= KIND_LINEAR;
      end else if (csr_we) begin
         unique case (csr_type'(csr_addr))
            CSR_POINTS: points_ff <= csr_wdata;
            CSR_LOOP:   loop_ff   <= csr_wdata[0];
            CSR_KIND:   kind_ff   <= kind_type'(csr_wdata[KIND_BITS-1:0]);
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         wr1_ff <= 1'b0;
         wr2_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_tvalid && cmd == CMD_EVAL};
         wr1_ff <= req_tvalid && cmd != CMD_EVAL;
         wr2_ff <= wr1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         wd1_ff <= req_tdata[101:0];
         wd2_ff <= wd1_ff;
      end
   end

   // table writes
   always_ff @(posedge clock) begin
      if (adv && wr2_ff && 32'(widx) < MAX_POINTS) begin
         for (int j = 0; j < 3; j++) begin
            unique case (wcmd)
               CMD_WR_POS:  pos_mem[IW'(widx)][j]  <= wv[j];
               CMD_WR_TIN:  tin_mem[IW'(widx)][j]  <= wv[j];
               CMD_WR_TOUT: tout_mem[IW'(widx)][j] <= wv[j];
               default:     ;
            endcase
         end
      end
   end

   // stages 1-2
   logic [IW-1:0]      i_m1, i_0, i_p1, i_p2;
   logic [FRAC_BITS:0] f2;
   logic               nz2, n12;

   csp_front #(.MAX_POINTS(MAX_POINTS), .IW(IW)) u_front (
      .clock         (clock),
      .enable        (adv),
      .points_in_use (points_ff),
      .loop_mode     (loop_ff),
      .curve_param   (req_tdata[118:102]),
      .idx_m1        (i_m1),
      .idx_0         (i_0),
      .idx_p1        (i_p1),
      .idx_p2        (i_p2),
      .frac          (f2),
      .n_zero        (nz2),
      .n_one         (n12)
   );

   // stage 3: table read
   logic signed [ACC_BITS-1:0] p0_ff[3], p1_ff[3], p2_ff[3], p3_ff[3];
   logic signed [ACC_BITS-1:0] to_ff[3], ti_ff[3];
   logic [FRAC_BITS:0]         f3_ff;
   mode_type                   m3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            p0_ff[j] <= pos_mem[i_m1][j];
            p1_ff[j] <= n12 ? pos_mem[0][j] : pos_mem[i_0][j];
            p2_ff[j] <= pos_mem[i_p1][j];
            p3_ff[j] <= pos_mem[i_p2][j];
            to_ff[j] <= tout_mem[i_0][j];
            ti_ff[j] <= tin_mem[i_p1][j];
         end
         f3_ff <= f2;
         m3_ff <= '{zero: nz2, single: n12,
                    halve: kind_ff == KIND_CATROM || kind_ff == KIND_CATALT};
      end
   end

   // stage 4: coefficients
   logic signed [ACC_BITS-1:0] c0_ff[3], c1_ff[3], c2_ff[3], c3_ff[3];
   logic [FRAC_BITS:0]         f4_ff;
   mode_type                   m4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            if (m3_ff.zero) begin
               c0_ff[j] <= '0; c1_ff[j] <= '0; c2_ff[j] <= '0; c3_ff[j] <= '0;
            end else if (m3_ff.single) begin
               c0_ff[j] <= p1_ff[j]; c1_ff[j] <= '0; c2_ff[j] <= '0;
               c3_ff[j] <= '0;
            end else begin
               unique case (kind_ff)
                  KIND_LINEAR: begin
                     c0_ff[j] <= p1_ff[j];
                     c1_ff[j] <= p2_ff[j] - p1_ff[j];
                     c2_ff[j] <= '0;
                     c3_ff[j] <= '0;
                  end
                  KIND_BEZIER: begin
                     c0_ff[j] <= p1_ff[j];
                     c1_ff[j] <= 3 * to_ff[j];
                     c2_ff[j] <= 3 * (ti_ff[j] - 2 * to_ff[j] + p2_ff[j] - p1_ff[j]);
                     c3_ff[j] <= 2 * (p1_ff[j] - p2_ff[j])
                                 + 3 * (to_ff[j] - ti_ff[j]);
                  end
                  default: begin
                     c0_ff[j] <= 2 * p1_ff[j];
                     c1_ff[j] <= p2_ff[j] - p0_ff[j];
                     c2_ff[j] <= 2 * p0_ff[j] - 5 * p1_ff[j] + 4 * p2_ff[j] - p3_ff[j];
                     c3_ff[j] <= 3 * (p1_ff[j] - p2_ff[j]) + p3_ff[j] - p0_ff[j];
                  end
               endcase
            end
         end
         f4_ff <= f3_ff;
         m4_ff <= m3_ff;
      end
   end

   // stages 5-7: Horner, coefficients delayed alongside
   logic signed [ACC_BITS-1:0] h5[3], h6[3], h7[3];
   logic signed [ACC_BITS-1:0] c1d5_ff[3], c0d5_ff[3], c0d6_ff[3];
   logic [FRAC_BITS:0]         f5_ff, f6_ff;
   mode_type                   m5_ff, m6_ff, m7_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            c1d5_ff[j] <= c1_ff[j];
            c0d5_ff[j] <= c0_ff[j];
            c0d6_ff[j] <= c0d5_ff[j];
         end
         f5_ff <= f4_ff;
         f6_ff <= f5_ff;
         m5_ff <= m4_ff;
         m6_ff <= m5_ff;
         m7_ff <= (m6_ff.zero || m6_ff.single) ? '{zero: 1'b0, single: 1'b0,
                  halve: 1'b0} : m6_ff;
      end
   end

   for (genvar j = 0; j < 3; j++) begin : g_lane
      csp_horner_step u_h5 (.clock(clock), .enable(adv), .acc(c3_ff[j]),
         .frac(f4_ff), .coef(c2_ff[j]), .acc_out(h5[j]));
      csp_horner_step u_h6 (.clock(clock), .enable(adv), .acc(h5[j]),
         .frac(f5_ff), .coef(c1d5_ff[j]), .acc_out(h6[j]));
      csp_horner_step u_h7 (.clock(clock), .enable(adv), .acc(h6[j]),
         .frac(f6_ff), .coef(c0d6_ff[j]), .acc_out(h7[j]));
   end

   // stage 8: halve and saturate
   localparam logic signed [ACC_BITS-1:0] LIM_HI = ACC_BITS'((64'sd1 <<< (EB-1)) - 1);
   localparam logic signed [ACC_BITS-1:0] LIM_LO = ACC_BITS'(-(64'sd1 <<< (EB-1)));

   logic signed [ACC_BITS-1:0] fin[3];
   logic [OUT_BITS-1:0]        out_ff[3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         fin[j] = m7_ff.halve ? (h7[j] + 1) >>> 1 : h7[j];
         if (fin[j] > LIM_HI) fin[j] = LIM_HI;
         if (fin[j] < LIM_LO) fin[j] = LIM_LO;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            out_ff[j] <= OUT_BITS'(fin[j]);
         end
      end
   end

   assign rsp_tdata = {out_ff[2], out_ff[1], out_ff[0]};

endmodule

`default_nettype wire

[rtl/csp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csp_checker
// Port-level checks for the spline evaluator.
// ----------------------------------------------------------------------------
module csp_checker import csp_pkg::*; (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [95:0]  rsp_tdata
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while output stalled");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result right after reset");

endmodule

bind cubic_spline_point_evaluator csp_checker u_csp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
